/* src/ds_twr_time_of_flight_defines.svh */
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight_defines
// assertion macros shared by the ranging block
// ----------------------------------------------------------------------------
`ifndef DS_TWR_TIME_OF_FLIGHT_DEFINES_SVH
`define DS_TWR_TIME_OF_FLIGHT_DEFINES_SVH

// checked on every rising edge of i_clk, quiet during reset
`define DSTWR_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

// next-cycle form
`define DSTWR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

/* src/dstwr_pkg.sv */
// ----------------------------------------------------------------------------
// dstwr_pkg
// shared types and constants of the two-way ranging time-of-flight block
// ----------------------------------------------------------------------------
package dstwr_pkg;

    localparam int QUOT_BITS   = 48;
    localparam int TOF_BITS    = 48;
    localparam int DIST_BITS   = 32;
    localparam int SCALE_BITS  = 24;
    localparam int SCALE_FRAC  = 16;
    localparam int TMAG_HALF   = 24;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd307387;
    localparam logic [TOF_BITS-1:0]   TOF_POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [TOF_BITS-1:0]   TOF_NEG_LIM = 48'h8000_0000_0000;
    localparam logic [DIST_BITS:0]    DIST_POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [DIST_BITS:0]    DIST_NEG_LIM = 33'h0_8000_0000;

    // per-item control traveling alongside the datapath
    typedef struct packed {
        logic valid;
        logic neg;
        logic zs;
        logic ovf;
    } t_side;

endpackage

/* src/dstwr_divider.sv */
// ----------------------------------------------------------------------------
// dstwr_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module dstwr_divider #(
    parameter int DW = 42
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  dstwr_pkg::t_side                 i_side,
    input  logic [DW-1:0]                    i_den,
    input  logic [DW-1:0]                    i_rem,
    input  logic [dstwr_pkg::QUOT_BITS-1:0]  i_lo,
    output dstwr_pkg::t_side                 o_side,
    output logic [dstwr_pkg::QUOT_BITS-1:0]  o_quot
);

    localparam int QB = dstwr_pkg::QUOT_BITS;

    dstwr_pkg::t_side  s_side [0:QB];
    logic [DW-1:0]     s_den  [0:QB];
    logic [DW-1:0]     s_rem  [0:QB];
    logic [QB-1:0]     s_lo   [0:QB];
    logic [QB-1:0]     s_quot [0:QB];

    assign s_side[0] = i_side;
    assign s_den[0]  = i_den;
    assign s_rem[0]  = i_rem;
    assign s_lo[0]   = i_lo;
    assign s_quot[0] = '0;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        dstwr_pkg::t_side r_side;
        logic [DW-1:0]    r_den;
        logic [DW-1:0]    r_rem;
        logic [QB-1:0]    r_lo;
        logic [QB-1:0]    r_quot;
        logic [DW:0]      n_trial;
        logic             n_ge;
        logic [DW:0]      n_diff;

        always_comb begin
            n_trial = {s_rem[k], s_lo[k][QB-1]};
            n_ge    = n_trial >= {1'b0, s_den[k]};
            n_diff  = n_trial - {1'b0, s_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= s_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den  <= s_den[k];
                r_rem  <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
                r_lo   <= {s_lo[k][QB-2:0], 1'b0};
                r_quot <= {s_quot[k][QB-2:0], n_ge};
            end
        end

        assign s_side[k+1] = r_side;
        assign s_den[k+1]  = r_den;
        assign s_rem[k+1]  = r_rem;
        assign s_lo[k+1]   = r_lo;
        assign s_quot[k+1] = r_quot;
    end

    assign o_side = s_side[QB];
    assign o_quot = s_quot[QB];

endmodule

/* src/ds_twr_time_of_flight.sv */
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight
// double-sided two-way ranging: time of flight and distance per exchange
// ----------------------------------------------------------------------------
// Input stream (s side): one transaction per exchange, tdata carries the
// peer's round and reply times and the local poll rx, response tx and final
// rx stamps. Output stream (m side): tdata holds the signed time of flight
// (16 fraction bits) and the signed distance in mm; tuser flags a zero
// denominator, in which case both values are zero.
// The stages: four of differencing and split multiplies (the first loads on
// the transaction), 48 divider stages producing one quotient bit each, one
// saturation/scale multiply stage and the output register. Throughput is
// one per cycle while the skid buffer is empty. The scale register is
// written through i_cfg_we/i_cfg_wdata, by the user only while idle; the
// block itself leaves this unchecked. Reset clears all valid bits and loads
// the default scale. When the receiver stalls, the output register holds
// its transaction and a one-entry skid buffer catches the next; the pipeline
// freezes only while the skid is occupied, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "ds_twr_time_of_flight_defines.svh"

module ds_twr_time_of_flight #(
    parameter int STAMP_BITS    = 40,
    parameter int TOF_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dstwr_pkg::SCALE_BITS-1:0]    i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // remote_round_time, remote_reply_time, poll_rx_stamp, resp_tx_stamp,
    // final_rx_stamp (lowest first), zero filled to whole bytes
    input  logic [((5*STAMP_BITS+7)/8)*8-1:0]   i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tof_fixed [47:0], distance_mm [79:48]
    output logic [79:0]                         o_m_tdata,
    // zero_sum
    output logic                                o_m_tuser
);

    localparam int SB = STAMP_BITS;
    localparam int DW = SB + 2;
    localparam int PW = 2 * SB;
    localparam int NW = PW + TOF_FRAC_BITS;
    localparam int QB = dstwr_pkg::QUOT_BITS;
    localparam int LB = (SB + 1) / 2;
    localparam int HB = SB - LB;
    localparam int TB = dstwr_pkg::TOF_BITS;
    localparam int DB = dstwr_pkg::DIST_BITS;
    localparam int CB = dstwr_pkg::SCALE_BITS;
    localparam int MH = dstwr_pkg::TMAG_HALF;
    localparam int XW = MH + CB + MH;
    localparam int SH = TOF_FRAC_BITS + dstwr_pkg::SCALE_FRAC;

    logic w_en;
    logic [CB-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= dstwr_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // ---------------- stage a: local intervals and denominator
    logic [SB-1:0] w_round1, w_reply2, w_poll, w_resp, w_final;
    assign w_round1 = i_s_tdata[SB-1:0];
    assign w_reply2 = i_s_tdata[2*SB-1:SB];
    assign w_poll   = i_s_tdata[3*SB-1:2*SB];
    assign w_resp   = i_s_tdata[4*SB-1:3*SB];
    assign w_final  = i_s_tdata[5*SB-1:4*SB];

    logic          r_a_valid, r_a_zs;
    logic [SB-1:0] r_a_round1, r_a_round2, r_a_reply1, r_a_reply2;
    logic [DW-1:0] r_a_den;
    logic [SB-1:0] n_reply1, n_round2;
    logic [DW-1:0] n_den;

    always_comb begin
        n_reply1 = w_resp - w_poll;
        n_round2 = w_final - w_resp;
        n_den    = DW'(w_round1) + DW'(n_round2) + DW'(n_reply1) + DW'(w_reply2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_round1 <= w_round1;
            r_a_round2 <= n_round2;
            r_a_reply1 <= n_reply1;
            r_a_reply2 <= w_reply2;
            r_a_den    <= n_den;
            r_a_zs     <= n_den == '0;
        end
    end

    // ---------------- stage b: split partial products
    logic              r_b_valid, r_b_zs;
    logic [DW-1:0]     r_b_den;
    logic [2*LB-1:0]   r_b_ll1, r_b_ll2;
    logic [LB+HB-1:0]  r_b_lh1, r_b_hl1, r_b_lh2, r_b_hl2;
    logic [2*HB-1:0]   r_b_hh1, r_b_hh2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_zs  <= r_a_zs;
            r_b_den <= r_a_den;
            r_b_ll1 <= (2*LB)'(r_a_round1[LB-1:0]) * (2*LB)'(r_a_round2[LB-1:0]);
            r_b_lh1 <= (LB+HB)'(r_a_round1[LB-1:0]) * (LB+HB)'(r_a_round2[SB-1:LB]);
            r_b_hl1 <= (LB+HB)'(r_a_round1[SB-1:LB]) * (LB+HB)'(r_a_round2[LB-1:0]);
            r_b_hh1 <= (2*HB)'(r_a_round1[SB-1:LB]) * (2*HB)'(r_a_round2[SB-1:LB]);
            r_b_ll2 <= (2*LB)'(r_a_reply1[LB-1:0]) * (2*LB)'(r_a_reply2[LB-1:0]);
            r_b_lh2 <= (LB+HB)'(r_a_reply1[LB-1:0]) * (LB+HB)'(r_a_reply2[SB-1:LB]);
            r_b_hl2 <= (LB+HB)'(r_a_reply1[SB-1:LB]) * (LB+HB)'(r_a_reply2[LB-1:0]);
            r_b_hh2 <= (2*HB)'(r_a_reply1[SB-1:LB]) * (2*HB)'(r_a_reply2[SB-1:LB]);
        end
    end

    // ---------------- stage c: assemble both products
    logic          r_c_valid, r_c_zs;
    logic [DW-1:0] r_c_den;
    logic [PW-1:0] r_c_p1, r_c_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_zs  <= r_b_zs;
            r_c_den <= r_b_den;
            r_c_p1  <= (PW'(r_b_hh1) << (2*LB)) + ((PW'(r_b_lh1) + PW'(r_b_hl1)) << LB)
                       + PW'(r_b_ll1);
            r_c_p2  <= (PW'(r_b_hh2) << (2*LB)) + ((PW'(r_b_lh2) + PW'(r_b_hl2)) << LB)
                       + PW'(r_b_ll2);
        end
    end

    // ---------------- stage d: signed difference, numerator, overflow check
    dstwr_pkg::t_side r_d_side;
    logic [DW-1:0]    r_d_den, r_d_rem;
    logic [QB-1:0]    r_d_lo;
    logic             n_ge;
    logic [PW-1:0]    n_mag;
    logic [NW-1:0]    n_num, n_num_hi;

    always_comb begin
        n_ge     = r_c_p1 >= r_c_p2;
        n_mag    = n_ge ? (r_c_p1 - r_c_p2) : (r_c_p2 - r_c_p1);
        n_num    = NW'(n_mag) << TOF_FRAC_BITS;
        n_num_hi = n_num >> QB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side <= '0;
        end else if (w_en) begin
            r_d_side.valid <= r_c_valid;
            r_d_side.neg   <= !n_ge;
            r_d_side.zs    <= r_c_zs;
            // quotient would not fit the divider's bits
            r_d_side.ovf   <= n_num_hi >= NW'(r_c_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_den <= r_c_den;
            r_d_rem <= n_num_hi[DW-1:0];
            r_d_lo  <= n_num[QB-1:0];
        end
    end

    // ---------------- divider
    dstwr_pkg::t_side w_q_side;
    logic [QB-1:0]    w_quot;

    dstwr_divider #(
        .DW(DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (r_d_side),
        .i_den   (r_d_den),
        .i_rem   (r_d_rem),
        .i_lo    (r_d_lo),
        .o_side  (w_q_side),
        .o_quot  (w_quot)
    );

    // ---------------- stage e: saturate tof, split scale multiply
    logic          r_e_valid, r_e_neg, r_e_zs;
    logic [TB-1:0] r_e_tof;
    logic [MH+CB-1:0] r_e_pl, r_e_ph;
    logic [TB-1:0] n_lim, n_tmag, n_tof;
    logic          n_neg;

    always_comb begin
        n_lim  = w_q_side.neg ? dstwr_pkg::TOF_NEG_LIM : dstwr_pkg::TOF_POS_LIM;
        n_tmag = (w_q_side.ovf || (TB'(w_quot) > n_lim)) ? n_lim : TB'(w_quot);
        n_neg  = w_q_side.neg && (n_tmag != '0);
        n_tof  = n_neg ? (TB'(0) - n_tmag) : n_tmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= w_q_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_neg <= n_neg;
            r_e_zs  <= w_q_side.zs;
            r_e_tof <= n_tof;
            r_e_pl  <= (MH+CB)'(n_tmag[MH-1:0]) * (MH+CB)'(r_scale);
            r_e_ph  <= (MH+CB)'(n_tmag[TB-1:MH]) * (MH+CB)'(r_scale);
        end
    end

    // ---------------- output stage: distance, saturation, skid buffer
    logic [XW-1:0] n_prod, n_dsh, n_dlim, n_dmag;
    logic [DB-1:0] n_dist;
    logic [79:0]   n_data;
    logic          n_user;

    always_comb begin
        n_prod = (XW'(r_e_ph) << MH) + XW'(r_e_pl);
        n_dsh  = n_prod >> SH;
        n_dlim = r_e_neg ? XW'(dstwr_pkg::DIST_NEG_LIM) : XW'(dstwr_pkg::DIST_POS_LIM);
        n_dmag = (n_dsh > n_dlim) ? n_dlim : n_dsh;
        n_dist = r_e_neg ? (DB'(0) - n_dmag[DB-1:0]) : n_dmag[DB-1:0];
        n_user = r_e_zs;
        n_data = r_e_zs ? '0 : {n_dist, r_e_tof};
    end

    logic        r_out_valid, r_skid_valid;
    logic [79:0] r_out_data, r_skid_data;
    logic        r_out_user, r_skid_user;
    logic        w_take;

    assign w_take = r_out_valid && i_m_tready;
    assign w_en   = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_e_valid) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (r_e_valid) begin
            if (r_out_valid && !w_take) begin
                r_skid_data <= n_data;
                r_skid_user <= n_user;
            end else begin
                r_out_data <= n_data;
                r_out_user <= n_user;
            end
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // ---------------- assertions
    `DSTWR_ASSERT_IMPLY(a_zero_sum_clears, r_out_valid && r_out_user,
        r_out_data == '0, "zero denominator result carries nonzero data")
    `DSTWR_ASSERT_IMPLY(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid buffer holds a transaction while output register is empty")
    `DSTWR_ASSERT_IMPLY(a_sign_match, r_out_valid && r_out_data[TB-1],
        r_out_data[79] || (r_out_data[79:TB] == '0),
        "negative time of flight gave positive distance")
    `DSTWR_ASSERT_NEXT(a_skid_drains, r_skid_valid && w_take, !r_skid_valid,
        "skid buffer not drained after output transaction")

endmodule
